>>> hw/rtl/boxds_pkg.sv
// Shared types, constants and the reciprocal table for the box-average downsampler.
package boxds_pkg;

  localparam int MAX_IN_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF    = 16;
  localparam int MAX_IN_HEIGHT    = 1024;
  localparam int ROW_W            = 10;   // row counter, values below MAX_IN_HEIGHT
  localparam int HGT_W            = 11;   // effective height, up to MAX_IN_HEIGHT

  localparam int PIXEL_W      = 8;
  localparam int SUM_W        = 16;
  localparam int SCALE_REG_W  = 5;
  localparam int DIM_REG_W    = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [SCALE_REG_W-1:0] SCALE_RST     = 5'd2;
  localparam logic [DIM_REG_W-1:0]   IN_WIDTH_RST  = 11'd320;
  localparam logic [DIM_REG_W-1:0]   IN_HEIGHT_RST = 11'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE     = 2'd0,
    REG_IN_WIDTH  = 2'd1,
    REG_IN_HEIGHT = 2'd2
  } cfg_reg_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               first;    // first pixel of a row segment of a block
    logic               load;     // segment adds onto a stored column sum
    logic               seg_end;  // last pixel of the row segment
    logic               emit;     // last pixel of the whole block
    logic               last;     // block is the final one of the frame
  } op_t;

  // ceil(2^24 / (s*s)) for s = 1..16; floor(n / s^2) = (n * R) >> 24 for n < 2^16.
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
    25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
    25'd671089,   25'd466034,  25'd342393,  25'd262144,
    25'd207127,   25'd167773,  25'd138655,  25'd116509,
    25'd99274,    25'd85599,   25'd74566,   25'd65536
  };

endpackage

>>> hw/rtl/boxds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module boxds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/boxds_fifo.sv
// Short queue between the classifying front and the accumulating back.
module boxds_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule

>>> hw/rtl/boxds_front.sv
// Front: configuration registers, frame position counters and pixel classification.
module boxds_front #(
  parameter int MAX_IN_WIDTH = boxds_pkg::MAX_IN_WIDTH_DEF,
  parameter int MAX_SCALE    = boxds_pkg::MAX_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [boxds_pkg::PIXEL_W-1:0]        in_pixel,
  input  logic                                 q_full,
  output logic                                 q_push,
  output boxds_pkg::op_t                       q_op,
  output logic [$clog2(MAX_IN_WIDTH)-1:0]      q_addr,
  output logic [boxds_pkg::RECIP_W-1:0]        recip
);

  import boxds_pkg::*;

  localparam int CW = $clog2(MAX_IN_WIDTH);
  localparam int DW = CW + 1;
  localparam int XW = DW + 1;
  localparam int YW = HGT_W + 1;
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int PW = $clog2(MAX_SCALE);

  logic [SCALE_REG_W-1:0] cfg_scale_r;
  logic [DIM_REG_W-1:0]   cfg_width_r;
  logic [DIM_REG_W-1:0]   cfg_height_r;

  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    bcol_r, bcol_nxt;
  logic [CW-1:0]    bstart_r, bstart_nxt;
  logic [PW-1:0]    cph_r, cph_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] rstart_r, rstart_nxt;
  logic [PW-1:0]    rph_r, rph_nxt;

  logic [SW-1:0]    s_eff;
  logic [DW-1:0]    w_eff;
  logic [HGT_W-1:0] h_eff;

  logic accept, restart;
  logic h_fit, v_fit, h_lastblk, v_lastblk;
  logic cph_last, rph_last, col_end, row_end;

  // Out-of-range register values are clamped into the legal ranges.
  always_comb begin
    if (cfg_scale_r == '0) begin
      s_eff = SW'(1);
    end else if (int'(cfg_scale_r) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(cfg_scale_r);
    end
    if (cfg_width_r == '0) begin
      w_eff = DW'(1);
    end else if (int'(cfg_width_r) > MAX_IN_WIDTH) begin
      w_eff = DW'(MAX_IN_WIDTH);
    end else begin
      w_eff = DW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (int'(cfg_height_r) > MAX_IN_HEIGHT) begin
      h_eff = HGT_W'(MAX_IN_HEIGHT);
    end else begin
      h_eff = HGT_W'(cfg_height_r);
    end
  end

  assign recip = RECIP_TABLE[4'(s_eff - SW'(1))];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign restart  = cfg_wr_en && ((cfg_index == REG_SCALE) || (cfg_index == REG_IN_WIDTH) ||
                                  (cfg_index == REG_IN_HEIGHT));

  // A block is inside the output image when it ends within the width / height.
  assign h_fit     = (XW'(bstart_r) + XW'(s_eff)) <= XW'(w_eff);
  assign v_fit     = (YW'(rstart_r) + YW'(s_eff)) <= YW'(h_eff);
  assign h_lastblk = (XW'(bstart_r) + XW'(s_eff) + XW'(s_eff)) > XW'(w_eff);
  assign v_lastblk = (YW'(rstart_r) + YW'(s_eff) + YW'(s_eff)) > YW'(h_eff);

  assign cph_last = (SW'(cph_r) + SW'(1)) == s_eff;
  assign rph_last = (SW'(rph_r) + SW'(1)) == s_eff;
  assign col_end  = (DW'(col_r) + DW'(1)) >= w_eff;
  assign row_end  = (HGT_W'(row_r) + HGT_W'(1)) >= h_eff;

  always_comb begin
    q_op.pixel   = in_pixel;
    q_op.first   = (cph_r == '0);
    q_op.load    = (rph_r != '0);
    q_op.seg_end = cph_last;
    q_op.emit    = cph_last && rph_last;
    q_op.last    = h_lastblk && v_lastblk;
  end

  assign q_addr = bcol_r;
  assign q_push = accept && h_fit && v_fit;

  always_comb begin
    col_nxt    = col_r;
    bcol_nxt   = bcol_r;
    bstart_nxt = bstart_r;
    cph_nxt    = cph_r;
    row_nxt    = row_r;
    rstart_nxt = rstart_r;
    rph_nxt    = rph_r;
    priority if (restart) begin
      col_nxt    = '0;
      bcol_nxt   = '0;
      bstart_nxt = '0;
      cph_nxt    = '0;
      row_nxt    = '0;
      rstart_nxt = '0;
      rph_nxt    = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt    = '0;
        bcol_nxt   = '0;
        bstart_nxt = '0;
        cph_nxt    = '0;
        if (row_end) begin
          row_nxt    = '0;
          rstart_nxt = '0;
          rph_nxt    = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
          if (rph_last) begin
            rph_nxt    = '0;
            rstart_nxt = row_r + ROW_W'(1);
          end else begin
            rph_nxt = rph_r + PW'(1);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (cph_last) begin
          cph_nxt    = '0;
          bcol_nxt   = bcol_r + CW'(1);
          bstart_nxt = col_r + CW'(1);
        end else begin
          cph_nxt = cph_r + PW'(1);
        end
      end
    end else begin
      // no transaction and no write: position holds
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_scale_r  <= SCALE_RST;
      cfg_width_r  <= IN_WIDTH_RST;
      cfg_height_r <= IN_HEIGHT_RST;
      col_r        <= '0;
      bcol_r       <= '0;
      bstart_r     <= '0;
      cph_r        <= '0;
      row_r        <= '0;
      rstart_r     <= '0;
      rph_r        <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_SCALE)) begin
        cfg_scale_r <= cfg_wr_data[SCALE_REG_W-1:0];
      end
      if (cfg_wr_en && (cfg_index == REG_IN_WIDTH)) begin
        cfg_width_r <= cfg_wr_data[DIM_REG_W-1:0];
      end
      if (cfg_wr_en && (cfg_index == REG_IN_HEIGHT)) begin
        cfg_height_r <= cfg_wr_data[DIM_REG_W-1:0];
      end
      col_r    <= col_nxt;
      bcol_r   <= bcol_nxt;
      bstart_r <= bstart_nxt;
      cph_r    <= cph_nxt;
      row_r    <= row_nxt;
      rstart_r <= rstart_nxt;
      rph_r    <= rph_nxt;
    end
  end

endmodule

>>> hw/rtl/boxds_back.sv
// Back: row-segment accumulation, column-sum line store, block mean and output register.
module boxds_back #(
  parameter int MAX_IN_WIDTH = boxds_pkg::MAX_IN_WIDTH_DEF,
  parameter int MAX_SCALE    = boxds_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  boxds_pkg::op_t                    q_op,
  input  logic [$clog2(MAX_IN_WIDTH)-1:0]   q_addr,
  output logic                              q_pop,
  input  logic [boxds_pkg::RECIP_W-1:0]     recip,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [boxds_pkg::PIXEL_W-1:0]     out_pixel,
  output logic                              out_frame_last
);

  import boxds_pkg::*;

  localparam int HA    = $clog2(MAX_SCALE * 255 + 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [HA-1:0]      hacc_r;
  logic [HA-1:0]      hbase, hsum;
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   rd_data;
  logic               rd_en, wr_en;

  logic               s1_valid_r;
  logic [SUM_W-1:0]   sum_r;
  logic               s1_last_r;
  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic               out_last_r;

  logic               out_adv, s1_adv;
  logic [PROD_W-1:0]  prod;
  logic [PIXEL_W-1:0] quot;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;

  // Only block-finishing pixels need room downstream.
  assign q_pop = q_valid && (!q_op.emit || s1_adv);

  assign hbase = q_op.first ? '0 : hacc_r;
  assign hsum  = hbase + HA'(q_op.pixel);
  assign total = SUM_W'(hsum) + (q_op.load ? rd_data : '0);

  // Stored sum fetched at segment start, consumed at segment end.
  assign rd_en = q_pop && q_op.first && q_op.load;
  assign wr_en = q_pop && q_op.seg_end && !q_op.emit;

  boxds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_IN_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_addr),
    .wr_data (total),
    .rd_en   (rd_en),
    .rd_addr (q_addr),
    .rd_data (rd_data)
  );

  assign prod = PROD_W'(sum_r) * PROD_W'(recip);
  assign quot = prod[RECIP_SHIFT+PIXEL_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_pop && q_op.emit;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hacc_r <= hsum;
    end
    if (s1_adv) begin
      sum_r     <= total;
      s1_last_r <= q_op.last;
    end
    if (out_adv) begin
      out_pixel_r <= quot;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en)
    else $error("line store read and write in one cycle");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_op.emit) |-> s1_adv)
    else $error("block result popped without room");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(sum_r)))
    else $error("stage 1 result lost under stall");

endmodule

>>> hw/rtl/box_average_downsampler_unit.sv
// Top level of the box-average image downsampler: front, queue and back.
//
//  channel  ports                                    direction  moves
//  in       in_valid/in_ready, in_pixel              input      one raster pixel
//  out      out_valid/out_ready, out_pixel,          output     one block mean
//           out_frame_last
//  cfg      cfg_wr_en, cfg_index, cfg_wr_data        input      one register write
//
//  Rate: one pixel transaction per clock while the queue is not full. A block mean
//  goes from the queue pop into stage 1, then through the multiply into the output
//  register.
//  The line store takes at most one read or one write per pixel.
//  Reset: configuration back to scale 2, 320 x 240; frame counters cleared; the line
//  store is not cleared (every entry is written before it is read).
//  Stalls: a held output fills the output register, then stage 1, then the 4-entry
//  queue; in_ready drops only when the queue is full.
module box_average_downsampler_unit #(
  parameter int MAX_IN_WIDTH = boxds_pkg::MAX_IN_WIDTH_DEF,
  parameter int MAX_SCALE    = boxds_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [boxds_pkg::PIXEL_W-1:0]     in_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [boxds_pkg::PIXEL_W-1:0]     out_pixel,
  output logic                              out_frame_last
);

  import boxds_pkg::*;

  localparam int CW = $clog2(MAX_IN_WIDTH);
  localparam int OW = $bits(op_t);
  localparam int QW = OW + CW;   // queue word: {column address, op}

  logic               q_full, q_push, q_valid, q_pop;
  op_t                push_op, pop_op;
  logic [CW-1:0]      push_addr, pop_addr;
  logic [QW-1:0]      q_rd_data;
  logic [RECIP_W-1:0] recip;

  // Front: counts pixels, drops those outside whole blocks, tags the rest.
  boxds_front #(
    .MAX_IN_WIDTH (MAX_IN_WIDTH),
    .MAX_SCALE    (MAX_SCALE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel    (in_pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (push_op),
    .q_addr      (push_addr),
    .recip       (recip)
  );

  // Queue decouples the front from output back-pressure.
  boxds_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({push_addr, push_op}),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  assign pop_op   = op_t'(q_rd_data[OW-1:0]);
  assign pop_addr = q_rd_data[QW-1:OW];

  // Back: sums segments into the line store and emits block means.
  boxds_back #(
    .MAX_IN_WIDTH (MAX_IN_WIDTH),
    .MAX_SCALE    (MAX_SCALE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (pop_op),
    .q_addr         (pop_addr),
    .q_pop          (q_pop),
    .recip          (recip),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

endmodule
